// ===== hdl/tks_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and sizes for the trie keyword scanner.
// ----------------------------------------------------------------------------
package tks_pkg;

  // trie sizing
  localparam int MAX_NODES   = 1024;
  localparam int ALPHABET    = 255;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int BYTE_W      = 8;
  localparam int ACT_W       = 2;
  localparam int SLOT_W      = 8;
  localparam int ADDR_W      = NODE_W + SLOT_W;
  localparam int CHILD_DEPTH = MAX_NODES * (2 ** SLOT_W);

  // item actions
  typedef enum logic [ACT_W-1:0] {
    ACT_SCAN   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_CLEAR  = 2'd2
  } tks_action_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHILD,
    ST_MARK,
    ST_DONE
  } tks_state_e;

endpackage

`default_nettype wire

// ===== hdl/tks_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_in_if / tks_out_if
// Valid/ready channels carrying scanner input words and result words.
// ----------------------------------------------------------------------------
interface tks_in_if import tks_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] data_byte;
  logic              first_byte;
  logic              last_byte;

  modport source (output valid, action, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, action, data_byte, first_byte, last_byte, output ready);
endinterface

interface tks_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic error;
  logic is_last;

  modport source (output valid, hit, error, is_last, input ready);
  modport sink   (input valid, hit, error, is_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/trie_keyword_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trie_keyword_scanner
// Multi-keyword matcher: patterns are inserted byte by byte into a trie held
// in a child memory, packet bytes walk the trie and flag a sticky hit.
// ----------------------------------------------------------------------------
//  channel   dir  word
//  in_i      in   action, data_byte, first_byte, last_byte
//  out_o     out  hit, error, is_last
//
//  a scan or insert word passes the child memory read (ST_CHILD); a scan
//  that lands on a node then reads the nonterminal mark (ST_MARK); ST_DONE
//  loads the result register, and input reopens only back in ST_IDLE.
//  after reset and after a clear word the child memory is swept to zero,
//  all CHILD_DEPTH (262144) entries, with in_i.ready low.
//  the result register frees the input side: a new word is taken while a
//  result still waits; a stalled out_o holds the sequencer in its last step.
// ----------------------------------------------------------------------------
module trie_keyword_scanner import tks_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  tks_in_if.sink     in_i,
  tks_out_if.source  out_o
);

  // control and walk state
  tks_state_e        state_q, state_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  tks_action_e       act_q, act_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;
  logic [NODE_W-1:0] cur_q, cur_d;
  logic [NODE_W-1:0] scan_cur_q, scan_cur_d;
  logic [NODE_W-1:0] ins_cur_q, ins_cur_d;
  logic [CNT_W-1:0]  nodes_q, nodes_d;
  logic              hit_q, hit_d;
  logic              err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_hit_d;
  logic              out_err_q, out_err_d;
  logic              out_last_q, out_last_d;

  // memories
  logic [NODE_W-1:0] child_mem [CHILD_DEPTH];
  logic              mark_mem  [MAX_NODES];
  logic [NODE_W-1:0] child_rd_q;
  logic              mark_rd_q;
  logic [ADDR_W-1:0] cm_raddr, cm_waddr;
  logic [NODE_W-1:0] cm_wdata;
  logic              cm_we;
  logic [NODE_W-1:0] mk_raddr, mk_waddr;
  logic              mk_wdata;
  logic              mk_we;

  logic              in_fire;
  logic              out_fire;
  logic [NODE_W-1:0] start_node;
  logic [SLOT_W-1:0] in_slot, q_slot;
  logic              q_byte_ok;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_valid_q && out_o.ready;
  assign in_slot  = SLOT_W'(in_i.data_byte - BYTE_W'(1));
  assign q_slot   = SLOT_W'(byte_q - BYTE_W'(1));
  // a byte has a child slot when it is nonzero and inside the alphabet
  assign q_byte_ok = (byte_q != '0) && (byte_q <= BYTE_W'(ALPHABET));

  // walk start: root on a first byte, else the action's cursor
  always_comb begin
    if (in_i.first_byte) begin
      start_node = '0;
    end else if (tks_action_e'(in_i.action) == ACT_INSERT) begin
      start_node = ins_cur_q;
    end else begin
      start_node = scan_cur_q;
    end
  end

  // child memory, registered read
  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      child_mem[cm_waddr] <= cm_wdata;
    end
    child_rd_q <= child_mem[cm_raddr];
  end

  // nonterminal mark memory: set once a node gains a child
  always_ff @(posedge clk_i) begin
    if (mk_we) begin
      mark_mem[mk_waddr] <= mk_wdata;
    end
    mark_rd_q <= mark_mem[mk_raddr];
  end

  // sequencer next state and datapath
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    act_d       = act_q;
    byte_d      = byte_q;
    last_d      = last_q;
    cur_d       = cur_q;
    scan_cur_d  = scan_cur_q;
    ins_cur_d   = ins_cur_q;
    nodes_d     = nodes_q;
    hit_d       = hit_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    cm_raddr    = {start_node, in_slot};
    cm_waddr    = {cur_q, q_slot};
    cm_wdata    = '0;
    cm_we       = 1'b0;
    mk_raddr    = child_rd_q;
    mk_waddr    = cur_q;
    mk_wdata    = 1'b0;
    mk_we       = 1'b0;
    in_i.ready  = 1'b0;

    if (out_fire) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        // zero one child entry and one mark a cycle
        cm_waddr = sweep_q;
        cm_wdata = '0;
        cm_we    = 1'b1;
        mk_waddr = sweep_q[NODE_W-1:0];
        mk_wdata = 1'b0;
        mk_we    = 1'b1;
        sweep_d  = sweep_q + ADDR_W'(1);
        if (sweep_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_fire) begin
          act_d  = tks_action_e'(in_i.action);
          byte_d = in_i.data_byte;
          last_d = in_i.last_byte;
          cur_d  = start_node;
          err_d  = 1'b0;
          case (tks_action_e'(in_i.action))
            ACT_SCAN: begin
              if (in_i.first_byte) begin
                hit_d = 1'b0;
              end
              state_d = ST_CHILD;
            end
            ACT_INSERT: begin
              state_d = ST_CHILD;
            end
            ACT_CLEAR: begin
              hit_d      = 1'b0;
              scan_cur_d = '0;
              ins_cur_d  = '0;
              nodes_d    = CNT_W'(1);
              state_d    = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_CHILD: begin
        if (act_q == ACT_SCAN) begin
          if (!q_byte_ok || child_rd_q == '0) begin
            scan_cur_d = '0;
            state_d    = ST_DONE;
          end else begin
            scan_cur_d = child_rd_q;
            state_d    = ST_MARK;
          end
        end else begin
          state_d = ST_DONE;
          if (!q_byte_ok) begin
            err_d = 1'b1;
          end else if (child_rd_q != '0) begin
            ins_cur_d = child_rd_q;
          end else if (nodes_q == CNT_W'(MAX_NODES)) begin
            err_d = 1'b1;
          end else begin
            // new leaf node, parent loses its terminal mark
            cm_wdata  = nodes_q[NODE_W-1:0];
            cm_we     = 1'b1;
            mk_wdata  = 1'b1;
            mk_we     = 1'b1;
            ins_cur_d = nodes_q[NODE_W-1:0];
            nodes_d   = nodes_q + CNT_W'(1);
          end
        end
      end
      ST_MARK: begin
        if (!mark_rd_q) begin
          hit_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // a last byte sends the cursor home (an insert's only when it had no error)
        if (last_q && act_q == ACT_SCAN) begin
          scan_cur_d = '0;
        end
        if (last_q && act_q == ACT_INSERT && !err_q) begin
          ins_cur_d = '0;
        end
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_hit_d   = hit_q;
          out_err_d   = err_q;
          out_last_d  = last_q;
          if (act_q == ACT_CLEAR) begin
            sweep_d = '0;
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      scan_cur_q  <= '0;
      ins_cur_q   <= '0;
      nodes_q     <= CNT_W'(1);
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      scan_cur_q  <= scan_cur_d;
      ins_cur_q   <= ins_cur_d;
      nodes_q     <= nodes_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    byte_q     <= byte_d;
    last_q     <= last_d;
    cur_q      <= cur_d;
    err_q      <= err_d;
    out_hit_q  <= out_hit_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  // result word
  assign out_o.valid   = out_valid_q;
  assign out_o.hit     = out_hit_q;
  assign out_o.error   = out_err_q;
  assign out_o.is_last = out_last_q;

endmodule

`default_nettype wire

// ===== hdl/tks_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tks_checker
// Port level checks for the trie keyword scanner, bound to the top level.
// ----------------------------------------------------------------------------
module tks_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire in_valid_i,
  input wire in_ready_i,
  input wire out_valid_i,
  input wire out_ready_i,
  input wire out_hit_i,
  input wire out_error_i,
  input wire out_is_last_i
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_hit_i) && $stable(out_error_i) && $stable(out_is_last_i))
    else $error("result word changed while stalled");

  // a result word leaves only through a handshake
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("result word dropped");

  // one word in flight: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second word taken while busy");

  // memory sweep follows reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |=> !in_ready_i)
    else $error("input open during sweep");

endmodule

bind trie_keyword_scanner tks_checker u_tks_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_hit_i     (out_o.hit),
  .out_error_i   (out_o.error),
  .out_is_last_i (out_o.is_last)
);

`default_nettype wire
